[rtl/spmc_pkg.sv]
// shared types, constants and register map for the stepper commutator
`default_nettype none
package spmc_pkg;
	localparam int MICROSTEPS_DEF = 128;

	// register indexes on the configuration port
	localparam logic [2:0] REG_REF_POS     = 3'd0;
	localparam logic [2:0] REG_KP          = 3'd1;
	localparam logic [2:0] REG_KI          = 3'd2;
	localparam logic [2:0] REG_KD          = 3'd3;
	localparam logic [2:0] REG_TICK_PERIOD = 3'd4;
	localparam logic [2:0] REG_DRIVE_GAIN  = 3'd5;
	localparam logic [2:0] REG_PWM_TOP     = 3'd6;

	localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;
	localparam logic signed [35:0] LIMIT_Q24  = 36'sd3355443200;
	localparam logic signed [36:0] LIMIT_Q16  = 37'sd13107200;

	// configuration register set
	typedef struct packed {
		logic signed [14:0] ref_pos;
		logic signed [23:0] kp;
		logic signed [23:0] ki;
		logic signed [23:0] kd;
		logic [31:0]        tick_period;
		logic [15:0]        drive_gain;
		logic [15:0]        pwm_top;
	} cfg_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_ERAD, OP_DRAD, OP_IMUL, OP_ICLAMP, OP_KP, OP_KI, OP_KD,
		OP_WCLAMP, OP_PMUL, OP_PHASE, OP_IDX, OP_RDS, OP_RDC, OP_AM1, OP_AM2, OP_AST,
		OP_BM2, OP_BST
	} op_t;

	// command from controller to datapath
	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;
endpackage
`default_nettype wire

[rtl/stepper_pid_microstep_commutator.sv]
// top level: configuration registers, controller and datapath
// Stepper position loop with sine microstep drive.
// Input channel: in_valid / in_stall carry one raw_angle item per control tick.
// Output channel: out_valid / out_stall carry the four bridge compare values
// and the clamped velocity command, one result item per input item.
// An item passes a PID step, a phase accumulator step, two sine table reads
// and two duty scalings on one shared multiplier, one operation per cycle.
// A new item is taken only after the previous result is loaded, so the block
// does not take a new item while one is still in work.
// in_stall is high while an item is in work. The result waits in an output
// register; if out_stall holds, the next item finishes and is held in the
// controller until that register frees.
// Reset clears the integral, previous error and phase, sets the registers to
// their defaults and leaves the block idle, ready at once.
// Registers sit at byte address 4*i on the APB port, written in the access
// phase; pready is always high. The sine table is constant logic.
`default_nettype none
module stepper_pid_microstep_commutator import spmc_pkg::*; #(
	parameter int MICROSTEPS = MICROSTEPS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [4:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire [13:0]        raw_angle,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [15:0]       phase_a_pos,
	output logic [15:0]       phase_a_neg,
	output logic [15:0]       phase_b_pos,
	output logic [15:0]       phase_b_neg,
	output logic signed [24:0] velocity_cmd
);
	cfg_t cfg_q;
	cmd_t cmd;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_pos     <= '0;
			cfg_q.kp          <= '0;
			cfg_q.ki          <= '0;
			cfg_q.kd          <= '0;
			cfg_q.tick_period <= 32'd4294967;
			cfg_q.drive_gain  <= 16'd32768;
			cfg_q.pwm_top     <= 16'd2799;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_REF_POS:     cfg_q.ref_pos     <= pwdata[14:0];
				REG_KP:          cfg_q.kp          <= pwdata[23:0];
				REG_KI:          cfg_q.ki          <= pwdata[23:0];
				REG_KD:          cfg_q.kd          <= pwdata[23:0];
				REG_TICK_PERIOD: cfg_q.tick_period <= pwdata;
				REG_DRIVE_GAIN:  cfg_q.drive_gain  <= pwdata[15:0];
				REG_PWM_TOP:     cfg_q.pwm_top     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[4:2])
			REG_REF_POS:     prdata = 32'(cfg_q.ref_pos);
			REG_KP:          prdata = 32'(cfg_q.kp);
			REG_KI:          prdata = 32'(cfg_q.ki);
			REG_KD:          prdata = 32'(cfg_q.kd);
			REG_TICK_PERIOD: prdata = cfg_q.tick_period;
			REG_DRIVE_GAIN:  prdata = {16'b0, cfg_q.drive_gain};
			REG_PWM_TOP:     prdata = {16'b0, cfg_q.pwm_top};
			default:         prdata = '0;
		endcase
	end

	spmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	spmc_dp #(.MICROSTEPS(MICROSTEPS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.raw_angle    (raw_angle),
		.phase_a_pos  (phase_a_pos),
		.phase_a_neg  (phase_a_neg),
		.phase_b_pos  (phase_b_pos),
		.phase_b_neg  (phase_b_neg),
		.velocity_cmd (velocity_cmd)
	);
endmodule
`default_nettype wire

[rtl/spmc_dp.sv]
// datapath: pid arithmetic, phase accumulator, sine table and duty scaling
`default_nettype none
module spmc_dp import spmc_pkg::*; #(
	parameter int MICROSTEPS = MICROSTEPS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cmd_t              cmd,
	input  cfg_t              cfg,
	input  wire [13:0]        raw_angle,
	output logic [15:0]       phase_a_pos,
	output logic [15:0]       phase_a_neg,
	output logic [15:0]       phase_b_pos,
	output logic [15:0]       phase_b_neg,
	output logic signed [24:0] velocity_cmd
);
	localparam int IW = $clog2(MICROSTEPS);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [15:0] rom_t [MICROSTEPS];

	// quarter sine by integer taylor series, terms to x^15 in q2.30
	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] v;
		for (int i = 0; i < MICROSTEPS; i++) begin
			x = (64'(i) * HALF_PI_Q30) / MICROSTEPS;
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			term = ((term * x2) >> 30) / 6;   sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 20;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 42;  sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 72;  sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 110; sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 156; sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 210; sum = sum - $signed(term);
			if (sum < 0) sum = 0;
			v = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) v = 64'd32767;
			r[i] = v[15:0];
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic signed [15:0] err_q;
	logic signed [15:0] prev_q;
	logic signed [21:0] erad_q;
	logic signed [22:0] drad_q;
	logic signed [34:0] integ_q;
	logic signed [52:0] wacc_q;
	logic signed [24:0] w_q;
	logic [31:0]        phase_q;
	logic [IW-1:0]      idx_q;
	logic [15:0]        sq_q, cq_q;
	logic               sneg_q, cneg_q;
	logic [15:0]        cmag_q;
	logic [15:0]        da_q, db_q;
	logic signed [69:0] prod_q;

	logic signed [35:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [14:0] pos;
	logic signed [16:0] diff;
	logic signed [35:0] isum;
	logic signed [52:0] wsum;
	logic signed [36:0] wsh;
	logic [40:0]        idx_full;
	logic [IW:0]        idx_rnd;
	logic [1:0]         quad;
	logic [15:0]        smag, cmag;

	// wrap encoder angle to signed counts
	assign pos  = (raw_angle > 14'd8192) ? $signed({1'b1, raw_angle})
		: $signed({1'b0, raw_angle});
	assign diff = 17'(err_q) - 17'(prev_q);
	assign isum = 36'(integ_q) + 36'($signed(prod_q[54:24]));
	assign wsum = wacc_q + prod_q[52:0];
	assign wsh  = wsum[52:16];

	// nearest microstep index, held below the quarter end
	assign idx_full = 41'(phase_q[29:0]) * 41'(MICROSTEPS) + (41'd1 << 29);
	assign idx_rnd  = idx_full[30+IW:30];

	// quadrant arrangement of sine and cosine
	assign quad = phase_q[31:30];
	assign smag = quad[0] ? cq_q : sq_q;
	assign cmag = quad[0] ? sq_q : cq_q;

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_ERAD: begin mul_a = 36'(err_q); mul_b = TWO_PI_Q16; end
			OP_DRAD: begin mul_a = 36'(diff); mul_b = TWO_PI_Q16; end
			OP_IMUL: begin mul_a = 36'(erad_q); mul_b = $signed({2'b0, cfg.tick_period}); end
			OP_KP:   begin mul_a = 36'(cfg.kp); mul_b = 34'(erad_q); end
			OP_KI:   begin mul_a = 36'(integ_q); mul_b = 34'(cfg.ki); end
			OP_KD:   begin mul_a = 36'(cfg.kd); mul_b = 34'(drad_q); end
			OP_PMUL: begin mul_a = 36'(w_q); mul_b = $signed({2'b0, cfg.tick_period}); end
			OP_AM1:  begin
				mul_a = $signed({20'b0, smag});
				mul_b = $signed({18'b0, cfg.drive_gain});
			end
			OP_AM2, OP_BM2: begin
				mul_a = $signed({4'b0, prod_q[31:0]});
				mul_b = $signed({18'b0, cfg.pwm_top});
			end
			OP_AST:  begin
				mul_a = $signed({20'b0, cmag_q});
				mul_b = $signed({18'b0, cfg.drive_gain});
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			phase_q <= '0;
		end else begin
			case (cmd.op)
				OP_ICLAMP: begin
					prev_q <= err_q;
					if (isum > LIMIT_Q24) integ_q <= 35'(LIMIT_Q24);
					else if (isum < -LIMIT_Q24) integ_q <= 35'(-LIMIT_Q24);
					else integ_q <= isum[34:0];
				end
				OP_PHASE: phase_q <= phase_q + prod_q[47:16];
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD:   err_q <= 16'(cfg.ref_pos) + 16'(pos);
			OP_DRAD:   erad_q <= prod_q[35:14];
			OP_IMUL:   drad_q <= prod_q[36:14];
			OP_KI:     wacc_q <= prod_q[52:0];
			OP_KD:     wacc_q <= wacc_q + prod_q[60:8];
			OP_WCLAMP: begin
				if (wsh > LIMIT_Q16) w_q <= 25'(LIMIT_Q16);
				else if (wsh < -LIMIT_Q16) w_q <= 25'(-LIMIT_Q16);
				else w_q <= wsh[24:0];
			end
			OP_IDX: idx_q <= (idx_rnd >= (IW+1)'(MICROSTEPS)) ? IW'(MICROSTEPS - 1)
				: idx_rnd[IW-1:0];
			OP_RDS: sq_q <= SINE_ROM[idx_q];
			OP_RDC: cq_q <= SINE_ROM[IW'(MICROSTEPS - 1) - idx_q];
			OP_AM1: begin
				sneg_q <= (quad == 2'd2 && sq_q != '0) || (quad == 2'd3 && cq_q != '0);
				cneg_q <= (quad == 2'd1 && sq_q != '0) || (quad == 2'd2 && cq_q != '0);
				cmag_q <= cmag;
			end
			OP_AST: da_q <= prod_q[46:31];
			OP_BST: db_q <= prod_q[46:31];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			phase_a_pos  <= sneg_q ? 16'd0 : da_q;
			phase_a_neg  <= sneg_q ? da_q : 16'd0;
			phase_b_pos  <= cneg_q ? 16'd0 : db_q;
			phase_b_neg  <= cneg_q ? db_q : 16'd0;
			velocity_cmd <= w_q;
		end
	end
endmodule
`default_nettype wire

[rtl/spmc_ctrl.sv]
// controller: sequences one item through the datapath and runs the handshakes
`default_nettype none
module spmc_ctrl import spmc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	output cmd_t cmd
);
	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001, ST_ERAD = 20'h00002, ST_DRAD = 20'h00004,
		ST_IMUL   = 20'h00008, ST_ICLAMP = 20'h00010, ST_KP = 20'h00020,
		ST_KI     = 20'h00040, ST_KD = 20'h00080, ST_WCLAMP = 20'h00100,
		ST_PMUL   = 20'h00200, ST_PHASE = 20'h00400, ST_IDX = 20'h00800,
		ST_RDS    = 20'h01000, ST_RDC = 20'h02000, ST_AM1 = 20'h04000,
		ST_AM2    = 20'h08000, ST_AST = 20'h10000, ST_BM2 = 20'h20000,
		ST_BST    = 20'h40000, ST_DONE = 20'h80000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// next state and datapath command
	always_comb begin
		state_nxt    = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd.op = OP_LOAD; state_nxt = ST_ERAD;
			end
			ST_ERAD:   begin cmd.op = OP_ERAD;   state_nxt = ST_DRAD; end
			ST_DRAD:   begin cmd.op = OP_DRAD;   state_nxt = ST_IMUL; end
			ST_IMUL:   begin cmd.op = OP_IMUL;   state_nxt = ST_ICLAMP; end
			ST_ICLAMP: begin cmd.op = OP_ICLAMP; state_nxt = ST_KP; end
			ST_KP:     begin cmd.op = OP_KP;     state_nxt = ST_KI; end
			ST_KI:     begin cmd.op = OP_KI;     state_nxt = ST_KD; end
			ST_KD:     begin cmd.op = OP_KD;     state_nxt = ST_WCLAMP; end
			ST_WCLAMP: begin cmd.op = OP_WCLAMP; state_nxt = ST_PMUL; end
			ST_PMUL:   begin cmd.op = OP_PMUL;   state_nxt = ST_PHASE; end
			ST_PHASE:  begin cmd.op = OP_PHASE;  state_nxt = ST_IDX; end
			ST_IDX:    begin cmd.op = OP_IDX;    state_nxt = ST_RDS; end
			ST_RDS:    begin cmd.op = OP_RDS;    state_nxt = ST_RDC; end
			ST_RDC:    begin cmd.op = OP_RDC;    state_nxt = ST_AM1; end
			ST_AM1:    begin cmd.op = OP_AM1;    state_nxt = ST_AM2; end
			ST_AM2:    begin cmd.op = OP_AM2;    state_nxt = ST_AST; end
			ST_AST:    begin cmd.op = OP_AST;    state_nxt = ST_BM2; end
			ST_BM2:    begin cmd.op = OP_BM2;    state_nxt = ST_BST; end
			ST_BST:    begin cmd.op = OP_BST;    state_nxt = ST_DONE; end
			ST_DONE: if (out_free) begin
				cmd.out_load = 1'b1; state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

[tb/spmc_checker.sv]
// checker: watches both channels and the register port, predicts and compares results
`timescale 1ns / 100ps
`default_nettype none
module spmc_checker import spmc_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [4:0]         paddr,
	input  wire [31:0]        pwdata,
	input  wire               pready,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire [13:0]        raw_angle,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire [15:0]        phase_a_pos,
	input  wire [15:0]        phase_a_neg,
	input  wire [15:0]        phase_b_pos,
	input  wire [15:0]        phase_b_neg,
	input  wire signed [24:0] velocity_cmd,
	output int                fail_count,
	output int                pending
);
	localparam int STEPS = MICROSTEPS_DEF;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [15:0]        a_pos;
		logic [15:0]        a_neg;
		logic [15:0]        b_pos;
		logic [15:0]        b_neg;
		logic signed [24:0] vel;
	} drive_t;

	cfg_t   regs;
	longint integ;
	longint last_err;
	logic [31:0] phase;
	logic [15:0] sine_tab [STEPS];
	drive_t drive_q [$];

	// quarter-wave table built from the fixed integer series
	initial begin
		longint unsigned x, x2, term, v;
		longint sum;
		fail_count = 0;
		for (int i = 0; i < STEPS; i++) begin
			x = (longint'(i) * HALF_PI_Q30) / STEPS;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int k = 1; k <= 7; k++) begin
				term = (term * x2) >> 30;
				term = term / ((2 * k) * (2 * k + 1));
				if (k % 2) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
			if (v > 32767) v = 32767;
			sine_tab[i] = v[15:0];
		end
	end

	function automatic longint to_rad(longint c);
		return (c * 411775) >>> 14;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [15:0] duty(longint m);
		longint unsigned d;
		d = (longint'(m) * regs.drive_gain * regs.pwm_top) >> 31;
		return d[15:0];
	endfunction

	// one control tick: pid, phase advance, table lookup, bridge scaling
	function automatic drive_t control_tick(logic [13:0] angle);
		longint pos, e, er, dr, w, s, c, sq, cq, tp;
		longint unsigned low, idx;
		logic [31:0] stepv;
		drive_t r;
		tp = longint'(regs.tick_period);
		pos = angle;
		if (pos > 8192) pos -= 16384;
		e = longint'(regs.ref_pos) + pos;
		er = to_rad(e);
		dr = to_rad(e - last_err);
		integ = clip(integ + ((er * tp) >>> 24), 64'sd3355443200);
		w = longint'(regs.kp) * er + ((longint'(regs.ki) * integ) >>> 8)
			+ longint'(regs.kd) * dr;
		w = clip(w >>> 16, 64'sd13107200);
		last_err = e;
		stepv = 32'((w * tp) >>> 16);
		phase = phase + stepv;
		low = phase[29:0];
		idx = (low * STEPS + (64'd1 << 29)) >> 30;
		if (idx >= STEPS) idx = STEPS - 1;
		sq = sine_tab[idx];
		cq = sine_tab[STEPS - 1 - idx];
		case (phase[31:30])
			2'd0: begin s = sq; c = cq; end
			2'd1: begin s = cq; c = -sq; end
			2'd2: begin s = -sq; c = -cq; end
			default: begin s = -cq; c = sq; end
		endcase
		r.a_pos = s >= 0 ? duty(s) : 16'd0;
		r.a_neg = s >= 0 ? 16'd0 : duty(-s);
		r.b_pos = c >= 0 ? duty(c) : 16'd0;
		r.b_neg = c >= 0 ? 16'd0 : duty(-c);
		r.vel = w[24:0];
		return r;
	endfunction

	// register writes, accepted items and result comparison
	always @(posedge clk or negedge arst_n) begin
		drive_t got, want;
		if (!arst_n) begin
			regs <= '{ref_pos: '0, kp: '0, ki: '0, kd: '0, tick_period: 32'd4294967,
				drive_gain: 16'd32768, pwm_top: 16'd2799};
			integ = 0;
			last_err = 0;
			phase = '0;
			drive_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_REF_POS:     regs.ref_pos <= pwdata[14:0];
					REG_KP:          regs.kp <= pwdata[23:0];
					REG_KI:          regs.ki <= pwdata[23:0];
					REG_KD:          regs.kd <= pwdata[23:0];
					REG_TICK_PERIOD: regs.tick_period <= pwdata;
					REG_DRIVE_GAIN:  regs.drive_gain <= pwdata[15:0];
					REG_PWM_TOP:     regs.pwm_top <= pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				drive_q.push_back(control_tick(raw_angle));
			if (out_valid && !out_stall) begin
				got = '{phase_a_pos, phase_a_neg, phase_b_pos, phase_b_neg, velocity_cmd};
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, got);
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (got.a_pos !== want.a_pos)
						$display("%0t: phase_a_pos expected %0d actual %0d", $time,
							want.a_pos, got.a_pos);
					if (got.a_neg !== want.a_neg)
						$display("%0t: phase_a_neg expected %0d actual %0d", $time,
							want.a_neg, got.a_neg);
					if (got.b_pos !== want.b_pos)
						$display("%0t: phase_b_pos expected %0d actual %0d", $time,
							want.b_pos, got.b_pos);
					if (got.b_neg !== want.b_neg)
						$display("%0t: phase_b_neg expected %0d actual %0d", $time,
							want.b_neg, got.b_neg);
					if (got.vel !== want.vel)
						$display("%0t: velocity_cmd expected %0d actual %0d", $time,
							want.vel, got.vel);
					if (got !== want) fail_count++;
				end
			end
		end
		pending = drive_q.size();
	end
endmodule
`default_nettype wire

[tb/tb_stepper_pid_microstep_commutator.sv]
// testbench top: clock, reset, register writes, angle stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_stepper_pid_microstep_commutator;
	import spmc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire [31:0] prdata;
	wire pready;
	logic in_valid = 1'b0;
	wire in_stall;
	logic [13:0] raw_angle = '0;
	wire out_valid;
	logic out_stall = 1'b0;
	wire [15:0] phase_a_pos, phase_a_neg, phase_b_pos, phase_b_neg;
	wire signed [24:0] velocity_cmd;
	int fail_count, pending;
	int idle_cycles = 0;
	int burst_left = 0;

	always #4 clk = ~clk;

	stepper_pid_microstep_commutator u_dut (.*);

	spmc_checker u_check (.*);

	// receiver stall pattern: free stretches, random, and mostly stalled
	always @(posedge clk) begin
		int mode;
		if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
		case (mode)
			1: out_stall <= ($urandom_range(0, 1) == 0);
			2: out_stall <= ($urandom_range(0, 4) != 0);
			default: out_stall <= 1'b0;
		endcase
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	// one register write; the bus is released by the caller
	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// stop sending and let the block drain
	task automatic drain();
		if (burst_left != 0) in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// one angle item, in bursts with random gaps
	task automatic send_angle(logic [13:0] a);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		raw_angle <= a;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	task automatic set_all(logic [31:0] rp, logic [31:0] p, logic [31:0] i, logic [31:0] d,
			logic [31:0] tp, logic [31:0] g, logic [31:0] top);
		reg_write(REG_REF_POS, rp);
		reg_write(REG_KP, p);
		reg_write(REG_KI, i);
		reg_write(REG_KD, d);
		reg_write(REG_TICK_PERIOD, tp);
		reg_write(REG_DRIVE_GAIN, g);
		reg_write(REG_PWM_TOP, top);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [13:0] edges [9] = '{14'd0, 14'd1, 14'd4096, 14'd8191, 14'd8192,
			14'd8193, 14'd12288, 14'd16383, 14'd10923};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero gains leave phase at zero
		foreach (edges[k]) send_angle(edges[k]);
		drain();
		// strong gains, long period: clamps and large phase steps
		set_all(32'h3FFF, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'hFFFFFFFF, 32'hFFFF, 32'hFFFF);
		foreach (edges[k]) send_angle(edges[k]);
		drain();
		// negative extremes, zero scaling and frozen period
		set_all(32'h4000, 32'h800000, 32'h800000, 32'h800000, 32'h0, 32'h0, 32'h0);
		send_angle(14'd100);
		send_angle(14'd16000);
		drain();
		set_all(32'h0, 32'h010000, 32'h0, 32'h0, 32'd1, 32'hFFFF, 32'd0);
		send_angle(14'd5000);
		send_angle(14'd9000);
		drain();

		// random phases of settings with random angles
		for (int ph = 0; ph < 8; ph++) begin
			set_all($urandom, $urandom, $urandom_range(0, 3) == 0 ? $urandom : '0,
				$urandom, ph % 3 == 0 ? $urandom : $urandom_range(1, 50000000),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			repeat (48) send_angle($urandom_range(0, 16383));
			drain();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
